// ===== src/fec_block_receive_tracker_macros.svh =====
// ---------------------------------------------------------------------------
// fec block receive tracker assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is held
// ---------------------------------------------------------------------------
`ifndef FEC_BLOCK_RECEIVE_TRACKER_MACROS_SVH
`define FEC_BLOCK_RECEIVE_TRACKER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FBRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FBRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fbrt_pkg.sv =====
// ---------------------------------------------------------------------------
// fbrt_pkg
// constants and types of the fec block receive tracker
// ---------------------------------------------------------------------------
package fbrt_pkg;

    localparam int BLOCKS  = 8;
    localparam int SLOTS   = 32;
    localparam int BLOCK_W = 3;
    localparam int SLOT_W  = 5;
    localparam int ROW_W   = 2 * SLOTS;
    // count width able to hold SLOTS itself
    localparam int CNT_W   = $clog2(SLOTS + 1);
    // slots are counted in groups of eight, then the groups are summed
    localparam int NGRP    = (SLOTS + 7) / 8;
    localparam int GRP_W   = 4;

    // field widths
    localparam int MODE_W     = 2;
    localparam int DCOUNT_W   = 6;
    localparam int PCOUNT_W   = 5;
    localparam int MISS_W     = 6;
    localparam int PAR_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 1'b1;

    localparam logic [DCOUNT_W-1:0] DCOUNT_RST = 6'd4;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 5'd1;

    typedef enum logic [1:0] {
        ST_ABSENT    = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_RECOVERED = 2'd2
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR     = 2'd0,
        MODE_RECEIVED  = 2'd1,
        MODE_RECOVERED = 2'd2,
        MODE_QUERY     = 2'd3
    } t_mode;

endpackage

// ===== src/fec_block_receive_tracker.sv =====
// ---------------------------------------------------------------------------
// fec_block_receive_tracker
// slot reception state (absent, present, recovered) of a ring of erasure-code
// blocks, with per-event data and parity counts
// ---------------------------------------------------------------------------
// One event is handled at a time: the block's row of slot states is read from
// a one-row-per-block memory, modified and written back with the count masks
// built, counted in groups of eight slots, and the group counts are summed into
// the output register, which waits while the output is stalled. The input
// accepts a new event as soon as the previous result sits in the output
// register, so no event is taken while another is still in flight.
// The read-modify-write of a row completes before the next event is taken, so
// no forwarding is needed. After reset every row reads as all absent by way
// of one valid flag per block; there is no clearing pass. A clear event
// rewrites the whole row in its single write-back.
// ---------------------------------------------------------------------------
`include "fec_block_receive_tracker_macros.svh"

module fec_block_receive_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fbrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbrt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [fbrt_pkg::MODE_W-1:0]         i_mode,
    input  logic [fbrt_pkg::BLOCK_W-1:0]        i_block,
    input  logic [fbrt_pkg::SLOT_W-1:0]         i_slot,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_was_inserted,
    output logic                                o_was_recovered,
    output logic [fbrt_pkg::MISS_W-1:0]         o_missing_data,
    output logic [fbrt_pkg::PAR_W-1:0]          o_present_parity,
    output logic                                o_decodable,
    output logic                                o_all_data_in
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_CNT,
        S_FIN
    } t_state;

    localparam int VEC_W = fbrt_pkg::NGRP * 8;

    t_state                              r_state;

    logic [fbrt_pkg::DCOUNT_W-1:0]       r_data_count;
    logic [fbrt_pkg::PCOUNT_W-1:0]       r_parity_count;

    // slot state memory, one row per block
    logic [fbrt_pkg::ROW_W-1:0]          mem [fbrt_pkg::BLOCKS];
    logic [fbrt_pkg::ROW_W-1:0]          r_rd_row;
    logic [fbrt_pkg::BLOCKS-1:0]         r_row_vld;

    fbrt_pkg::t_mode                     r_mode;
    logic [fbrt_pkg::BLOCK_W-1:0]        r_block;
    logic [fbrt_pkg::SLOT_W-1:0]         r_slot;
    logic                                r_row_ok;

    logic [1:0]                          r_prev;
    logic [VEC_W-1:0]                    r_miss_vec;
    logic [VEC_W-1:0]                    r_par_vec;
    logic [fbrt_pkg::GRP_W-1:0]          r_miss_grp [fbrt_pkg::NGRP];
    logic [fbrt_pkg::GRP_W-1:0]          r_par_grp  [fbrt_pkg::NGRP];

    logic                                r_out_valid;
    logic                                r_out_ins;
    logic                                r_out_rec;
    logic [fbrt_pkg::MISS_W-1:0]         r_out_miss;
    logic [fbrt_pkg::PAR_W-1:0]          r_out_par;
    logic                                r_out_dec;
    logic                                r_out_all;

    logic                                w_accept;
    logic                                w_in_blk_ok;
    logic                                w_blk_ok;
    logic                                w_slot_ok;
    logic [fbrt_pkg::CNT_W-1:0]          w_k_eff;
    logic [fbrt_pkg::CNT_W-1:0]          w_pend;
    logic [fbrt_pkg::ROW_W-1:0]          w_old_row;
    logic [fbrt_pkg::ROW_W-1:0]          w_new_row;
    logic [1:0]                          w_prev;
    logic [VEC_W-1:0]                    w_miss_vec;
    logic [VEC_W-1:0]                    w_par_vec;
    logic                                w_mem_we;
    logic [fbrt_pkg::GRP_W-1:0]          w_miss_grp [fbrt_pkg::NGRP];
    logic [fbrt_pkg::GRP_W-1:0]          w_par_grp  [fbrt_pkg::NGRP];
    logic [fbrt_pkg::CNT_W-1:0]          w_miss_sum;
    logic [fbrt_pkg::CNT_W-1:0]          w_par_sum;
    logic                                w_out_load;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    assign w_in_blk_ok = ({1'b0, i_block} < (fbrt_pkg::BLOCK_W + 1)'(fbrt_pkg::BLOCKS));
    assign w_blk_ok    = ({1'b0, r_block} < (fbrt_pkg::BLOCK_W + 1)'(fbrt_pkg::BLOCKS));
    assign w_slot_ok   = w_blk_ok &&
                         ({1'b0, r_slot} < (fbrt_pkg::SLOT_W + 1)'(fbrt_pkg::SLOTS));

    // data slots limited to the row, parity slots to what is left of it
    always_comb begin
        logic [fbrt_pkg::CNT_W:0] sum;
        if ({1'b0, r_data_count} > (fbrt_pkg::DCOUNT_W + 1)'(fbrt_pkg::SLOTS)) begin
            w_k_eff = fbrt_pkg::CNT_W'(fbrt_pkg::SLOTS);
        end else begin
            w_k_eff = fbrt_pkg::CNT_W'(r_data_count);
        end
        sum = {1'b0, w_k_eff} + (fbrt_pkg::CNT_W + 1)'(r_parity_count);
        if (sum > (fbrt_pkg::CNT_W + 1)'(fbrt_pkg::SLOTS)) begin
            w_pend = fbrt_pkg::CNT_W'(fbrt_pkg::SLOTS);
        end else begin
            w_pend = sum[fbrt_pkg::CNT_W-1:0];
        end
    end

    // row update and count masks
    always_comb begin
        logic [1:0]                  st;
        logic [fbrt_pkg::CNT_W-1:0]  idx;
        w_old_row = r_row_ok ? r_rd_row : '0;
        w_prev    = w_slot_ok ? w_old_row[{r_slot, 1'b0} +: 2] : fbrt_pkg::ST_ABSENT;
        w_new_row = w_old_row;
        unique case (r_mode)
            fbrt_pkg::MODE_CLEAR: begin
                w_new_row = '0;
            end
            fbrt_pkg::MODE_RECEIVED: begin
                if (w_slot_ok) begin
                    w_new_row[{r_slot, 1'b0} +: 2] = fbrt_pkg::ST_PRESENT;
                end
            end
            fbrt_pkg::MODE_RECOVERED: begin
                if (w_slot_ok && (fbrt_pkg::CNT_W'(r_slot) < w_k_eff) &&
                    (w_prev != fbrt_pkg::ST_PRESENT)) begin
                    w_new_row[{r_slot, 1'b0} +: 2] = fbrt_pkg::ST_RECOVERED;
                end
            end
            fbrt_pkg::MODE_QUERY: begin
            end
            default: begin
            end
        endcase
        w_miss_vec = '0;
        w_par_vec  = '0;
        for (int i = 0; i < fbrt_pkg::SLOTS; i++) begin
            st  = w_new_row[2*i +: 2];
            idx = fbrt_pkg::CNT_W'(i);
            w_miss_vec[i] = (idx < w_k_eff) && (st == fbrt_pkg::ST_ABSENT);
            w_par_vec[i]  = (idx >= w_k_eff) && (idx < w_pend) &&
                            (st == fbrt_pkg::ST_PRESENT);
        end
    end

    assign w_mem_we = (r_state == S_MOD) && w_blk_ok;

    // per-group popcounts
    always_comb begin
        for (int g = 0; g < fbrt_pkg::NGRP; g++) begin
            w_miss_grp[g] = '0;
            w_par_grp[g]  = '0;
            for (int b = 0; b < 8; b++) begin
                w_miss_grp[g] = w_miss_grp[g] + fbrt_pkg::GRP_W'(r_miss_vec[8*g + b]);
                w_par_grp[g]  = w_par_grp[g] + fbrt_pkg::GRP_W'(r_par_vec[8*g + b]);
            end
        end
    end

    always_comb begin
        w_miss_sum = '0;
        w_par_sum  = '0;
        for (int g = 0; g < fbrt_pkg::NGRP; g++) begin
            w_miss_sum = w_miss_sum + fbrt_pkg::CNT_W'(r_miss_grp[g]);
            w_par_sum  = w_par_sum + fbrt_pkg::CNT_W'(r_par_grp[g]);
        end
    end

    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_block] <= w_new_row;
        end
        if (w_accept) begin
            r_rd_row <= mem[i_block];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_data_count   <= fbrt_pkg::DCOUNT_RST;
            r_parity_count <= fbrt_pkg::PCOUNT_RST;
            r_row_vld      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fbrt_pkg::CFG_DATA_COUNT: begin
                        r_data_count <= i_cfg_data[fbrt_pkg::DCOUNT_W-1:0];
                    end
                    fbrt_pkg::CFG_PARITY_COUNT: begin
                        r_parity_count <= i_cfg_data[fbrt_pkg::PCOUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_mem_we) begin
                r_row_vld[r_block] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= fbrt_pkg::t_mode'(i_mode);
            r_block  <= i_block;
            r_slot   <= i_slot;
            r_row_ok <= w_in_blk_ok && r_row_vld[i_block];
        end
        if (r_state == S_MOD) begin
            r_prev     <= w_prev;
            r_miss_vec <= w_miss_vec;
            r_par_vec  <= w_par_vec;
        end
        if (r_state == S_CNT) begin
            r_miss_grp <= w_miss_grp;
            r_par_grp  <= w_par_grp;
        end
        if (w_out_load) begin
            r_out_ins  <= (r_prev != fbrt_pkg::ST_ABSENT);
            r_out_rec  <= (r_prev == fbrt_pkg::ST_RECOVERED);
            r_out_miss <= fbrt_pkg::MISS_W'(w_miss_sum);
            r_out_par  <= fbrt_pkg::PAR_W'(w_par_sum);
            r_out_dec  <= (w_miss_sum <= w_par_sum);
            r_out_all  <= (w_miss_sum == '0);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_was_inserted   = r_out_ins;
    assign o_was_recovered  = r_out_rec;
    assign o_missing_data   = r_out_miss;
    assign o_present_parity = r_out_par;
    assign o_decodable      = r_out_dec;
    assign o_all_data_in    = r_out_all;

    `FBRT_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, w_accept, o_stall, "no stall after input transfer")
    `FBRT_ASSERT_IMPLY(a_rec_is_ins, i_clk, i_rst_n, o_valid, !o_was_recovered || o_was_inserted, "recovered slot reported as absent")
    `FBRT_ASSERT_IMPLY(a_all_in_flag, i_clk, i_rst_n, o_valid, o_all_data_in == (o_missing_data == '0), "all-data flag disagrees with count")
    `FBRT_ASSERT_IMPLY(a_dec_flag, i_clk, i_rst_n, o_valid, o_decodable == ({1'b0, o_missing_data} <= {2'b0, o_present_parity}), "decodable flag disagrees with counts")
    `FBRT_ASSERT_IMPLY(a_miss_range, i_clk, i_rst_n, o_valid, {1'b0, o_missing_data} <= 7'(fbrt_pkg::SLOTS), "missing count above slot count")

endmodule

// ===== sim/fec_block_receive_tracker_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fec_block_receive_tracker_tb
// self-checking bench: events are queued per block life (clear, arrivals,
// recoveries, queries) over a range of data and parity counts, driven in
// bursts against a stalling receiver, and every result is checked field by
// field against a slot-state predictor kept in step with accepted transfers
// ---------------------------------------------------------------------------
module fec_block_receive_tracker_tb;
    import fbrt_pkg::*;

    localparam int PHASE_ITEMS = 105;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        t_mode              mode;
        logic [BLOCK_W-1:0] block;
        logic [SLOT_W-1:0]  slot;
    } t_event;

    typedef struct packed {
        logic              was_inserted;
        logic              was_recovered;
        logic [MISS_W-1:0] missing_data;
        logic [PAR_W-1:0]  present_parity;
        logic              decodable;
        logic              all_data_in;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [MODE_W-1:0]     i_mode = '0;
    logic [BLOCK_W-1:0]    i_block = '0;
    logic [SLOT_W-1:0]     i_slot = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_was_inserted;
    logic                  o_was_recovered;
    logic [MISS_W-1:0]     o_missing_data;
    logic [PAR_W-1:0]      o_present_parity;
    logic                  o_decodable;
    logic                  o_all_data_in;

    fec_block_receive_tracker u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_block          (i_block),
        .i_slot           (i_slot),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_was_inserted   (o_was_inserted),
        .o_was_recovered  (o_was_recovered),
        .o_missing_data   (o_missing_data),
        .o_present_parity (o_present_parity),
        .o_decodable      (o_decodable),
        .o_all_data_in    (o_all_data_in)
    );

    // predictor state
    t_status             slot_state [BLOCKS][SLOTS];
    logic [DCOUNT_W-1:0] k_cfg = DCOUNT_RST;
    logic [PCOUNT_W-1:0] h_cfg = PCOUNT_RST;

    t_event   pending_events [$];
    t_outcome predicted_outcomes [$];

    int n_queued = 0;
    int n_events = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_decodable = 0;
    int n_complete = 0;
    int n_settings = 0;
    int cycle_cnt = 0;

    // sender and receiver idling controls, set per phase
    int          send_gap_max = 3;
    int          stall_density = 1;
    int          burst_left = 1;
    int          gap_left = 0;
    logic [15:0] stall_bits = '0;
    logic [3:0]  stall_step = '0;
    int          hold_trigger = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_outcome apply_event(input t_event ev);
        t_outcome res;
        t_status  prev;
        int       k;
        int       span;
        int       miss;
        int       par;
        k = (k_cfg > SLOTS) ? SLOTS : int'(k_cfg);
        span = k + int'(h_cfg);
        if (span > SLOTS) span = SLOTS;
        prev = slot_state[ev.block][ev.slot];
        case (ev.mode)
            MODE_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) slot_state[ev.block][i] = ST_ABSENT;
            end
            MODE_RECEIVED: begin
                slot_state[ev.block][ev.slot] = ST_PRESENT;
            end
            MODE_RECOVERED: begin
                // parity slots and already present slots are left alone
                if (int'(ev.slot) < k && prev != ST_PRESENT)
                    slot_state[ev.block][ev.slot] = ST_RECOVERED;
            end
            default: ;
        endcase
        miss = 0;
        par = 0;
        for (int i = 0; i < k; i++)
            if (slot_state[ev.block][i] == ST_ABSENT) miss++;
        for (int i = k; i < span; i++)
            if (slot_state[ev.block][i] == ST_PRESENT) par++;
        res.was_inserted   = (prev != ST_ABSENT);
        res.was_recovered  = (prev == ST_RECOVERED);
        res.missing_data   = MISS_W'(miss);
        res.present_parity = PAR_W'(par);
        res.decodable      = (miss <= par);
        res.all_data_in    = (miss == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (n_errors < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     n_results, what, got, want);
        n_errors++;
    endtask

    task automatic queue_event(input t_mode mode, input int blk, input int slot);
        t_event ev;
        ev.mode = mode;
        ev.block = BLOCK_W'(blk);
        ev.slot = SLOT_W'(slot);
        pending_events.push_back(ev);
        n_queued++;
    endtask

    // mostly within the active slots, now and then anywhere in the block
    function automatic int pick_slot(input int span);
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, span - 1);
        return $urandom_range(0, SLOTS - 1);
    endfunction

    task automatic queue_block_life(input int blk);
        int k;
        int span;
        int n;
        int roll;
        k = (k_cfg > SLOTS) ? SLOTS : int'(k_cfg);
        span = k + int'(h_cfg);
        if (span > SLOTS) span = SLOTS;
        if (span < 1) span = 1;
        queue_event(MODE_CLEAR, blk, $urandom_range(0, SLOTS - 1));
        n = span + $urandom_range(0, span / 2 + 2);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                queue_event(t_mode'($urandom_range(0, 3)), $urandom_range(0, BLOCKS - 1),
                            $urandom_range(0, SLOTS - 1));
            end else if (roll < 60) begin
                queue_event(MODE_RECEIVED, blk, pick_slot(span));
            end else if (roll < 82) begin
                queue_event(MODE_RECOVERED, blk, pick_slot(span));
            end else begin
                queue_event(MODE_QUERY, blk, pick_slot(span));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || predicted_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DATA_COUNT) k_cfg = val;
        else h_cfg = val[PCOUNT_W-1:0];
    endtask

    task automatic run_phase(input int k, input int h, input int gap_max,
                             input int density, input bit long_hold);
        int phase_end;
        wait_idle();
        write_reg(CFG_DATA_COUNT, CFG_DATA_W'(k));
        write_reg(CFG_PARITY_COUNT, CFG_DATA_W'(h));
        n_settings++;
        @(negedge i_clk);
        send_gap_max = gap_max;
        stall_density = density;
        phase_end = n_queued + PHASE_ITEMS;
        while (n_queued < phase_end) queue_block_life($urandom_range(0, BLOCKS - 1));
        // receiver holds off while the sender keeps offering
        if (long_hold) hold_trigger++;
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predicted_outcomes.push_back(apply_event(pending_events[0]));
                pending_events.delete(0);
                n_events++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    i_valid <= 1'b1;
                    i_mode <= pending_events[0].mode;
                    i_block <= pending_events[0].block;
                    i_slot <= pending_events[0].slot;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        if (send_gap_max > 0) gap_left <= $urandom_range(1, send_gap_max);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: checks each result transfer and stalls on a rotating pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (predicted_outcomes.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 8'd1, 8'd0);
                end else begin
                    if (o_was_inserted !== predicted_outcomes[0].was_inserted)
                        report_mismatch("was_inserted", 8'(o_was_inserted),
                                        8'(predicted_outcomes[0].was_inserted));
                    if (o_was_recovered !== predicted_outcomes[0].was_recovered)
                        report_mismatch("was_recovered", 8'(o_was_recovered),
                                        8'(predicted_outcomes[0].was_recovered));
                    if (o_missing_data !== predicted_outcomes[0].missing_data)
                        report_mismatch("missing_data", 8'(o_missing_data),
                                        8'(predicted_outcomes[0].missing_data));
                    if (o_present_parity !== predicted_outcomes[0].present_parity)
                        report_mismatch("present_parity", 8'(o_present_parity),
                                        8'(predicted_outcomes[0].present_parity));
                    if (o_decodable !== predicted_outcomes[0].decodable)
                        report_mismatch("decodable", 8'(o_decodable),
                                        8'(predicted_outcomes[0].decodable));
                    if (o_all_data_in !== predicted_outcomes[0].all_data_in)
                        report_mismatch("all_data_in", 8'(o_all_data_in),
                                        8'(predicted_outcomes[0].all_data_in));
                    if (predicted_outcomes[0].decodable) n_decodable++;
                    if (predicted_outcomes[0].all_data_in) n_complete++;
                    predicted_outcomes.delete(0);
                end
                n_results++;
            end
            stall_step <= stall_step + 4'd1;
            if (stall_step == 4'd15) begin
                case (stall_density)
                    0: stall_bits <= '0;
                    1: stall_bits <= 16'($urandom & $urandom & $urandom);
                    2: stall_bits <= 16'($urandom & $urandom);
                    default: stall_bits <= 16'($urandom | $urandom);
                endcase
            end else begin
                stall_bits <= {stall_bits[0], stall_bits[15:1]};
            end
            i_stall <= (hold_left > 0) || stall_bits[0];
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_cnt);
            $display("[fec_block_receive_tracker] ERROR");
            $finish;
        end
    end

    initial begin
        for (int b = 0; b < BLOCKS; b++)
            for (int s = 0; s < SLOTS; s++) slot_state[b][s] = ST_ABSENT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed events under the reset counts (four data, one parity)
        queue_event(MODE_QUERY, 0, 0);         // empty block
        queue_event(MODE_RECEIVED, 0, 0);
        queue_event(MODE_RECEIVED, 0, 4);      // parity slot
        queue_event(MODE_RECOVERED, 0, 1);     // absent data slot recovered
        queue_event(MODE_RECOVERED, 0, 0);     // present slot stays present
        queue_event(MODE_RECOVERED, 0, 4);     // parity slot ignored
        queue_event(MODE_RECOVERED, 0, 1);     // recovered again
        queue_event(MODE_RECEIVED, 0, 1);      // recovered becomes present
        queue_event(MODE_RECEIVED, 0, 2);
        queue_event(MODE_RECEIVED, 0, 3);      // all data in
        queue_event(MODE_RECEIVED, 0, 31);     // beyond data and parity
        queue_event(MODE_QUERY, 0, 31);
        queue_event(MODE_CLEAR, 0, 1);         // reports state before clear
        queue_event(MODE_QUERY, 0, 1);
        queue_event(MODE_RECEIVED, 7, 31);
        queue_event(MODE_QUERY, 7, 31);
        queue_event(MODE_CLEAR, 7, 0);
        queue_event(MODE_QUERY, 7, 31);
        queue_event(MODE_RECOVERED, 5, 3);
        queue_event(MODE_QUERY, 5, 3);
        queue_event(MODE_CLEAR, 5, 3);
        queue_event(MODE_RECOVERED, 5, 0);
        queue_event(MODE_RECOVERED, 5, 2);
        queue_event(MODE_RECEIVED, 5, 4);      // two data missing, one parity: not decodable
        queue_event(MODE_QUERY, 3, 16);

        // each phase starts once the previous one has fully drained
        run_phase(4, 1, 4, 1, 1'b0);
        run_phase(1, 0, 0, 0, 1'b0);
        run_phase(32, 0, 6, 2, 1'b1);
        run_phase(16, 16, 2, 3, 1'b0);
        run_phase(8, 31, 0, 1, 1'b0);          // parity runs past the block end
        run_phase(0, 5, 5, 2, 1'b0);           // no data slots
        run_phase(63, 3, 3, 0, 1'b0);          // data count beyond the block
        run_phase(33, 31, 1, 1, 1'b0);
        run_phase(20, 6'h2C, 4, 2, 1'b0);      // upper write bit dropped for parity
        run_phase(1, 31, 2, 1, 1'b0);
        run_phase(10, 4, 8, 3, 1'b1);

        while (pending_events.size() != 0 || predicted_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d events over %0d register settings, %0d results checked",
                 n_events, n_settings, n_results);
        $display("%0d results decodable, %0d with all data in, %0d mismatches",
                 n_decodable, n_complete, n_errors);
        if (n_errors == 0 && predicted_outcomes.size() == 0) begin
            $display("[fec_block_receive_tracker] OK");
        end else begin
            $display("[fec_block_receive_tracker] ERROR");
        end
        $finish;
    end

endmodule
